[sv/spom_pkg.sv]
package spom_pkg;

    localparam int MAX_ROWS    = 16;
    localparam int MAX_COLUMNS = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int DEPTH       = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int SIZE_W      = 5;
    localparam int BOUND_W     = 5;
    localparam int POS_W       = 4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    localparam logic [1:0] DIR_RIGHT = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_UP    = 2'd3;

    typedef struct packed {
        logic load_we;
        logic fetch;
        logic emit;
        logic err_emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic loaded;
    } dp_status_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max_v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > max_v)
        begin
            r = max_v;
        end
        return r;
    endfunction

endpackage

[sv/spiral_order_matrix_reader.sv]
// Spiral order matrix reader.
// Configure row_count (index 0) and column_count (index 1) through cfg_we,
// cfg_index and cfg_data while idle; any write restarts loading and readout.
// Input channel (in_valid/in_stall): cmd = 0 loads value_in as the next
// element in row-major order, cmd = 1 requests the next element in clockwise
// spiral order. Output channel (out_valid/out_stall) carries value_out, its
// row_index/column_index, last_element on the final element, and
// not_loaded_error for a read that arrives before loading completes.
// Loads are accepted one per cycle while the input is not stalled. A read result
// passes through the registered read of the element store and then the output
// register, with the input stalled during the fetch. Errors skip the fetch.
// Loads beyond the matrix size are dropped without a result.
// After reset the size is 1 x 1, all counters and bounds are cleared, and
// the store contents are undefined until loaded.
// While the output register holds a result under out_stall, the input is
// stalled; the result holds until transferred.
module spiral_order_matrix_reader (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic                                    cfg_index,
    input  logic [spom_pkg::SIZE_W-1:0]             cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    cmd,
    input  logic signed [spom_pkg::DATA_WIDTH-1:0]  value_in,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [spom_pkg::DATA_WIDTH-1:0]  value_out,
    output logic [spom_pkg::POS_W-1:0]              row_index,
    output logic [spom_pkg::POS_W-1:0]              column_index,
    output logic                                    last_element,
    output logic                                    not_loaded_error
);

    spom_pkg::ctrl_cmd_t  ctrl;
    spom_pkg::dp_status_t status;

    spom_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    spom_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .value_in         (value_in),
        .ctrl             (ctrl),
        .status           (status),
        .value_out        (value_out),
        .row_index        (row_index),
        .column_index     (column_index),
        .last_element     (last_element),
        .not_loaded_error (not_loaded_error)
    );

endmodule

[sv/spom_ctrl.sv]
module spom_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    output logic                   out_valid,
    input  logic                   out_stall,
    input  spom_pkg::dp_status_t   status,
    output spom_pkg::ctrl_cmd_t    ctrl
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FETCH = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;

    assign in_stall  = (state_reg == ST_FETCH) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == spom_pkg::CMD_LOAD)
                    begin
                        ctrl.load_we = 1'b1;
                    end
                    else if (status.loaded)
                    begin
                        ctrl.fetch = 1'b1;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        ctrl.err_emit = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                ctrl.emit  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.emit || ctrl.err_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/spom_dp.sv]
module spom_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic                                    cfg_index,
    input  logic [spom_pkg::SIZE_W-1:0]             cfg_data,
    input  logic signed [spom_pkg::DATA_WIDTH-1:0]  value_in,
    input  spom_pkg::ctrl_cmd_t                     ctrl,
    output spom_pkg::dp_status_t                    status,
    output logic signed [spom_pkg::DATA_WIDTH-1:0]  value_out,
    output logic [spom_pkg::POS_W-1:0]              row_index,
    output logic [spom_pkg::POS_W-1:0]              column_index,
    output logic                                    last_element,
    output logic                                    not_loaded_error
);

    localparam int SW = spom_pkg::SIZE_W;
    localparam int BW = spom_pkg::BOUND_W;
    localparam int PW = spom_pkg::POS_W;
    localparam int CW = spom_pkg::CNT_W;
    localparam int AW = spom_pkg::ADDR_W;
    localparam int DW = spom_pkg::DATA_WIDTH;
    localparam logic [SW-1:0] MAX_R = SW'(spom_pkg::MAX_ROWS);
    localparam logic [SW-1:0] MAX_C = SW'(spom_pkg::MAX_COLUMNS);

    logic [SW-1:0] rows_reg, rows_next, cols_reg, cols_next;
    logic [SW-1:0] eff_r, eff_c, eff_r_next, eff_c_next;
    logic [CW-1:0] total;
    logic [CW-1:0] load_cnt_reg, load_cnt_next;
    logic [CW-1:0] emit_cnt_reg, emit_cnt_next, emit_inc;
    logic [BW-1:0] top_reg, top_next, bottom_reg, bottom_next;
    logic [BW-1:0] left_reg, left_next, right_reg, right_next;
    logic [1:0]    dir_reg, dir_next;
    logic [PW-1:0] row_reg, row_next, col_reg, col_next;
    logic          is_last;
    logic          load_ok;
    logic [AW-1:0] rd_addr;

    logic [DW-1:0] mem [spom_pkg::DEPTH];
    logic [DW-1:0] mem_q;

    assign eff_r      = spom_pkg::clamp_size(rows_reg, MAX_R);
    assign eff_c      = spom_pkg::clamp_size(cols_reg, MAX_C);
    assign eff_r_next = spom_pkg::clamp_size(rows_next, MAX_R);
    assign eff_c_next = spom_pkg::clamp_size(cols_next, MAX_C);
    assign total      = {{(CW-SW){1'b0}}, eff_r} * {{(CW-SW){1'b0}}, eff_c};
    assign emit_inc   = CW'(emit_cnt_reg + 1'b1);
    assign is_last    = (emit_inc >= total);
    assign load_ok    = ctrl.load_we && (load_cnt_reg < total);
    assign rd_addr    = {{(AW-PW){1'b0}}, row_reg} * {{(AW-SW){1'b0}}, eff_c}
                        + {{(AW-PW){1'b0}}, col_reg};
    assign status.loaded = (load_cnt_reg >= total);

    always_comb
    begin
        rows_next = rows_reg;
        cols_next = cols_reg;
        if (cfg_we)
        begin
            if (cfg_index == spom_pkg::REG_ROW_COUNT)
            begin
                rows_next = cfg_data;
            end
            else
            begin
                cols_next = cfg_data;
            end
        end
    end

    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        top_next      = top_reg;
        bottom_next   = bottom_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        dir_next      = dir_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        if (cfg_we || (ctrl.emit && is_last))
        begin
            load_cnt_next = '0;
            emit_cnt_next = '0;
            top_next      = '0;
            bottom_next   = BW'(eff_r_next - 1'b1);
            left_next     = '0;
            right_next    = BW'(eff_c_next - 1'b1);
            dir_next      = spom_pkg::DIR_RIGHT;
            row_next      = '0;
            col_next      = '0;
        end
        else if (ctrl.emit)
        begin
            emit_cnt_next = emit_inc;
            case (dir_reg)
                spom_pkg::DIR_RIGHT:
                begin
                    if ({1'b0, col_reg} < right_reg)
                    begin
                        col_next = PW'(col_reg + 1'b1);
                    end
                    else
                    begin
                        top_next = BW'(top_reg + 1'b1);
                        dir_next = spom_pkg::DIR_DOWN;
                        row_next = top_next[PW-1:0];
                    end
                end
                spom_pkg::DIR_DOWN:
                begin
                    if ({1'b0, row_reg} < bottom_reg)
                    begin
                        row_next = PW'(row_reg + 1'b1);
                    end
                    else
                    begin
                        right_next = BW'(right_reg - 1'b1);
                        dir_next   = spom_pkg::DIR_LEFT;
                        col_next   = right_next[PW-1:0];
                    end
                end
                spom_pkg::DIR_LEFT:
                begin
                    if ({1'b0, col_reg} > left_reg)
                    begin
                        col_next = PW'(col_reg - 1'b1);
                    end
                    else
                    begin
                        bottom_next = BW'(bottom_reg - 1'b1);
                        dir_next    = spom_pkg::DIR_UP;
                        row_next    = bottom_next[PW-1:0];
                    end
                end
                default:
                begin
                    if ({1'b0, row_reg} > top_reg)
                    begin
                        row_next = PW'(row_reg - 1'b1);
                    end
                    else
                    begin
                        left_next = BW'(left_reg + 1'b1);
                        dir_next  = spom_pkg::DIR_RIGHT;
                        col_next  = left_next[PW-1:0];
                    end
                end
            endcase
        end
        else if (load_ok)
        begin
            load_cnt_next = CW'(load_cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= SW'(1);
            cols_reg     <= SW'(1);
            load_cnt_reg <= '0;
            emit_cnt_reg <= '0;
            top_reg      <= '0;
            bottom_reg   <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            dir_reg      <= spom_pkg::DIR_RIGHT;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            load_cnt_reg <= load_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
            top_reg      <= top_next;
            bottom_reg   <= bottom_next;
            left_reg     <= left_next;
            right_reg    <= right_next;
            dir_reg      <= dir_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
        end
    end

    // element store, registered read
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            mem[load_cnt_reg[AW-1:0]] <= value_in;
        end
        if (ctrl.fetch)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            value_out        <= mem_q;
            row_index        <= row_reg;
            column_index     <= col_reg;
            last_element     <= is_last;
            not_loaded_error <= 1'b0;
        end
        else if (ctrl.err_emit)
        begin
            value_out        <= '0;
            row_index        <= '0;
            column_index     <= '0;
            last_element     <= 1'b0;
            not_loaded_error <= 1'b1;
        end
    end

endmodule

[sv/spom_chk.sv]
module spom_chk (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    cfg_we,
    input logic                                    cfg_index,
    input logic [spom_pkg::SIZE_W-1:0]             cfg_data,
    input logic                                    in_valid,
    input logic                                    in_stall,
    input logic                                    cmd,
    input logic signed [spom_pkg::DATA_WIDTH-1:0]  value_in,
    input logic                                    out_valid,
    input logic                                    out_stall,
    input logic signed [spom_pkg::DATA_WIDTH-1:0]  value_out,
    input logic [spom_pkg::POS_W-1:0]              row_index,
    input logic [spom_pkg::POS_W-1:0]              column_index,
    input logic                                    last_element,
    input logic                                    not_loaded_error
);

    logic in_xfer;
    assign in_xfer = in_valid && !in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_out)
            && $stable(last_element) && $stable(not_loaded_error))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_loaded_error |-> value_out == 0 && row_index == 0
            && column_index == 0 && !last_element)
        else $error("error result carries data");

    a_read_progress: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && cmd == spom_pkg::CMD_READ |=> in_stall || out_valid)
        else $error("read transfer made no progress");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && cmd == spom_pkg::CMD_LOAD |=> !$rose(out_valid))
        else $error("load produced a result");

endmodule

bind spiral_order_matrix_reader spom_chk u_chk (.*);

[tb/sv/spiral_reader_checker.sv]
module spiral_reader_checker
    import spom_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [SIZE_W-1:0]             cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          cmd,
    input  logic signed [DATA_WIDTH-1:0]  value_in,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [DATA_WIDTH-1:0]  value_out,
    input  logic [POS_W-1:0]              row_index,
    input  logic [POS_W-1:0]              column_index,
    input  logic                          last_element,
    input  logic                          not_loaded_error,
    output int                            fail_count,
    output int                            pending_count
);

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic [POS_W-1:0]             row;
        logic [POS_W-1:0]             col;
        logic                         is_last;
        logic                         is_error;
    } spiral_result_t;

    spiral_result_t        spiral_due[$];
    spiral_result_t        got_r;
    spiral_result_t        exp_r;
    logic [DATA_WIDTH-1:0] matrix_mem [DEPTH];
    logic [SIZE_W-1:0]     rows_reg;
    logic [SIZE_W-1:0]     cols_reg;
    int                    load_cnt;
    int                    emit_cnt;
    logic [BOUND_W-1:0]    top_b;
    logic [BOUND_W-1:0]    bottom_b;
    logic [BOUND_W-1:0]    left_b;
    logic [BOUND_W-1:0]    right_b;
    logic [1:0]            heading;
    int                    cur_row;
    int                    cur_col;
    int                    mismatches;

    function automatic int size_in_use(input logic [SIZE_W-1:0] v, input int max_v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > max_v)
        begin
            return max_v;
        end
        return int'(v);
    endfunction

    task automatic rewind_walk();
        load_cnt = 0;
        emit_cnt = 0;
        top_b    = '0;
        bottom_b = BOUND_W'(size_in_use(rows_reg, MAX_ROWS) - 1);
        left_b   = '0;
        right_b  = BOUND_W'(size_in_use(cols_reg, MAX_COLUMNS) - 1);
        heading  = DIR_RIGHT;
        cur_row  = 0;
        cur_col  = 0;
    endtask

    task automatic next_spiral_result(input logic op, input logic [DATA_WIDTH-1:0] v);
        spiral_result_t r;
        int             cols;
        int             total;
        int             addr;
        cols  = size_in_use(cols_reg, MAX_COLUMNS);
        total = size_in_use(rows_reg, MAX_ROWS) * cols;
        r     = '0;
        if (op == CMD_LOAD)
        begin
            if (load_cnt < total)
            begin
                matrix_mem[load_cnt] = v;
                load_cnt++;
            end
        end
        else if (load_cnt < total)
        begin
            r.is_error = 1'b1;
            spiral_due.insert(spiral_due.size(), r);
        end
        else
        begin
            addr = cur_row * cols + cur_col;
            if (addr >= DEPTH)
            begin
                addr = 0;
            end
            r.value = matrix_mem[addr];
            r.row   = POS_W'(cur_row);
            r.col   = POS_W'(cur_col);
            emit_cnt++;
            if (emit_cnt >= total)
            begin
                r.is_last = 1'b1;
                rewind_walk();
            end
            else
            begin
                case (heading)
                    DIR_RIGHT:
                    begin
                        if (cur_col < right_b)
                        begin
                            cur_col++;
                        end
                        else
                        begin
                            top_b++;
                            heading = DIR_DOWN;
                            cur_row = top_b;
                        end
                    end
                    DIR_DOWN:
                    begin
                        if (cur_row < bottom_b)
                        begin
                            cur_row++;
                        end
                        else
                        begin
                            right_b = right_b - 1'b1;
                            heading = DIR_LEFT;
                            cur_col = right_b;
                        end
                    end
                    DIR_LEFT:
                    begin
                        if (cur_col > left_b)
                        begin
                            cur_col--;
                        end
                        else
                        begin
                            bottom_b = bottom_b - 1'b1;
                            heading  = DIR_UP;
                            cur_row  = bottom_b;
                        end
                    end
                    default:
                    begin
                        if (cur_row > top_b)
                        begin
                            cur_row--;
                        end
                        else
                        begin
                            left_b++;
                            heading = DIR_RIGHT;
                            cur_col = left_b;
                        end
                    end
                endcase
            end
            spiral_due.insert(spiral_due.size(), r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   = 5'd1;
            cols_reg   = 5'd1;
            rewind_walk();
            spiral_due.delete();
            mismatches = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got_r = {value_out, row_index, column_index, last_element, not_loaded_error};
                if (spiral_due.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end
                else
                begin
                    exp_r = spiral_due.pop_front();
                    if (got_r.value !== exp_r.value)
                    begin
                        $error("value_out: expected %0d, got %0d", exp_r.value, got_r.value);
                        mismatches++;
                    end
                    if (got_r.row !== exp_r.row)
                    begin
                        $error("row_index: expected %0d, got %0d", exp_r.row, got_r.row);
                        mismatches++;
                    end
                    if (got_r.col !== exp_r.col)
                    begin
                        $error("column_index: expected %0d, got %0d", exp_r.col, got_r.col);
                        mismatches++;
                    end
                    if (got_r.is_last !== exp_r.is_last)
                    begin
                        $error("last_element: expected %0d, got %0d",
                               exp_r.is_last, got_r.is_last);
                        mismatches++;
                    end
                    if (got_r.is_error !== exp_r.is_error)
                    begin
                        $error("not_loaded_error: expected %0d, got %0d",
                               exp_r.is_error, got_r.is_error);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_ROW_COUNT)
                begin
                    rows_reg = cfg_data;
                end
                else
                begin
                    cols_reg = cfg_data;
                end
                rewind_walk();
            end
            if (in_valid && !in_stall)
            begin
                next_spiral_result(cmd, value_in);
            end
            fail_count    <= mismatches;
            pending_count <= spiral_due.size();
        end
    end

endmodule

[tb/sv/tb.sv]
module tb;
    import spom_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 450;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_we = 1'b0;
    logic                         cfg_index = REG_ROW_COUNT;
    logic [SIZE_W-1:0]            cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         cmd = CMD_LOAD;
    logic signed [DATA_WIDTH-1:0] value_in = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [DATA_WIDTH-1:0] value_out;
    logic [POS_W-1:0]             row_index;
    logic [POS_W-1:0]             column_index;
    logic                         last_element;
    logic                         not_loaded_error;
    int                           fail_count;
    int                           pending_count;

    int       cycle_count = 0;
    int       burst_left = 0;
    int       items_sent = 0;
    int       rows_use = 1;
    int       cols_use = 1;
    logic [8:0] stall_clock = '0;

    spiral_order_matrix_reader i_dut (.*);

    spiral_reader_checker i_checker (.*);

    always #5 clk = ~clk;

    // receiver: out_stall pattern rotates through four modes
    always @(posedge clk)
    begin
        stall_clock <= stall_clock + 1'b1;
        case (stall_clock[8:7])
            2'd0:    out_stall <= 1'b0;
            2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
            2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (stall_clock[2:0] < 3'd3);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** spiral_order_matrix_reader: FAILED **");
            $finish;
        end
    end

    function automatic int size_in_use(input logic [SIZE_W-1:0] v, input int max_v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > max_v)
        begin
            return max_v;
        end
        return int'(v);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_word();
        logic [DATA_WIDTH-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = 32'h8000_0000;
            1:       w = 32'h7FFF_FFFF;
            2:       w = '1;
            3:       w = '0;
            default: w = $urandom();
        endcase
        return w;
    endfunction

    task automatic send_item(input logic op, input logic [DATA_WIDTH-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        value_in <= v;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        items_sent++;
    endtask

    // wait for every result, then cover a load still in flight
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic set_sizes(input logic wr_rows, input logic wr_cols,
                             input logic [SIZE_W-1:0] rows_val,
                             input logic [SIZE_W-1:0] cols_val);
        if (wr_rows)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_ROW_COUNT;
            cfg_data  <= rows_val;
            @(posedge clk);
            rows_use = size_in_use(rows_val, MAX_ROWS);
        end
        if (wr_cols)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= REG_COLUMN_COUNT;
            cfg_data  <= cols_val;
            @(posedge clk);
            cols_use = size_in_use(cols_val, MAX_COLUMNS);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [SIZE_W-1:0] rows_val;
        logic [SIZE_W-1:0] cols_val;
        logic              wr_rows;
        logic              wr_cols;
        logic              forced;
        logic              broken;
        logic              rewrite;
        int                phase;
        int                total;
        int                n_load;
        int                n_read;
        int                pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 1 x 1 after reset: early read, load, load past the end, read, read after wrap
        send_item(CMD_READ, '0);
        send_item(CMD_LOAD, 32'h7FFF_FFFF);
        send_item(CMD_LOAD, 32'h8000_0000);
        send_item(CMD_READ, '1);
        send_item(CMD_READ, '0);
        settle();

        // 2 x 3 with an early read and a load during readout
        set_sizes(1'b1, 1'b1, 5'd2, 5'd3);
        send_item(CMD_LOAD, 32'h8000_0000);
        send_item(CMD_LOAD, '1);
        send_item(CMD_LOAD, '0);
        send_item(CMD_READ, 32'h5555_5555);
        send_item(CMD_LOAD, 32'd1);
        send_item(CMD_LOAD, 32'h5555_5555);
        send_item(CMD_LOAD, 32'hAAAA_AAAA);
        send_item(CMD_READ, '0);
        send_item(CMD_READ, '0);
        send_item(CMD_READ, '0);
        send_item(CMD_LOAD, 32'h1234_5678);
        send_item(CMD_READ, '0);
        send_item(CMD_READ, '0);
        send_item(CMD_READ, '0);

        phase   = 0;
        rewrite = 1'b1;
        while (items_sent < ITEM_TARGET)
        begin
            forced = 1'b1;
            case (phase)
                1:
                begin
                    rows_val = 5'd0;
                    cols_val = 5'd31;
                end
                4:
                begin
                    rows_val = 5'd17;
                    cols_val = 5'd0;
                end
                7:
                begin
                    rows_val = 5'd31;
                    cols_val = 5'd4;
                end
                default:
                begin
                    forced = 1'b0;
                    pick   = $urandom_range(0, 3);
                    rows_val = (pick == 0) ? 5'($urandom_range(0, 31)) :
                               (pick == 1) ? 5'($urandom_range(1, 4)) :
                                             5'($urandom_range(1, 6));
                    cols_val = (pick == 1) ? 5'($urandom_range(0, 31)) :
                               (pick == 0) ? 5'($urandom_range(1, 4)) :
                                             5'($urandom_range(1, 6));
                end
            endcase

            pick = $urandom_range(0, 7);
            wr_rows = forced || rewrite || pick == 2 || pick > 3;
            wr_cols = forced || rewrite || pick == 3 || pick > 3;
            if (wr_rows || wr_cols)
            begin
                settle();
                set_sizes(wr_rows, wr_cols, rows_val, cols_val);
            end

            total  = rows_use * cols_use;
            broken = !forced && ($urandom_range(0, 9) == 0);
            n_load = broken ? $urandom_range(0, total) : total;
            if (n_load < total)
            begin
                n_read = $urandom_range(0, 3);
            end
            else
            begin
                n_read = broken ? $urandom_range(0, total - 1) : total;
            end

            for (int i = 0; i < n_load; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    send_item(CMD_READ, rand_word());
                end
                send_item(CMD_LOAD, rand_word());
            end
            for (int i = 0; i < n_read; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                begin
                    send_item(CMD_LOAD, rand_word());
                end
                send_item(CMD_READ, rand_word());
            end

            rewrite = broken;
            phase++;
        end

        settle();
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("** spiral_order_matrix_reader: PASSED **");
        end
        else
        begin
            $display("** spiral_order_matrix_reader: FAILED **");
        end
        $finish;
    end

endmodule
